### src/fwmb_pkg.sv
// Package for the FIFO with membership bitmap: sizes, widths, command and status codes.
// It has no dependencies. The interfaces and the top level use it through scoped names.
`default_nettype none

package fwmb_pkg;

  // Sizes of the vertex bitmap and of the entry ring.
  localparam int NUM_VERTICES = 1024;
  localparam int QUEUE_DEPTH  = 1024;

  // Payload field widths.
  localparam int CMD_W    = 2;
  localparam int VIDX_W   = 10;
  localparam int COLOR_W  = 10;
  localparam int QCOUNT_W = 11;
  localparam int STATUS_W = 2;

  // Internal widths that follow from the sizes.
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int VADDR_W = $clog2(NUM_VERTICES);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OUT_RANGE = 2'd3;

  // One ring slot.
  typedef struct packed {
    logic [VIDX_W-1:0]  vidx;
    logic [COLOR_W-1:0] color;
  } entry_t;

endpackage

`default_nettype wire

### src/fwmb_if.sv
// Valid/ready channel interfaces for commands and results of the FIFO with membership bitmap.
// Depends on fwmb_pkg for the field widths.
`default_nettype none

interface fwmb_req_if;
  logic                           valid;
  logic                           ready;
  logic [fwmb_pkg::CMD_W-1:0]     cmd;
  logic [fwmb_pkg::VIDX_W-1:0]    vertex_index;
  logic [fwmb_pkg::COLOR_W-1:0]   vertex_color;

  modport source (output valid, cmd, vertex_index, vertex_color, input ready);
  modport sink   (input valid, cmd, vertex_index, vertex_color, output ready);
endinterface

interface fwmb_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [fwmb_pkg::VIDX_W-1:0]    front_index;
  logic [fwmb_pkg::COLOR_W-1:0]   front_color;
  logic                           front_valid;
  logic [fwmb_pkg::QCOUNT_W-1:0]  queue_count;
  logic                           is_member;
  logic [fwmb_pkg::STATUS_W-1:0]  status;

  modport source (output valid, front_index, front_color, front_valid, queue_count,
                  is_member, status, input ready);
  modport sink   (input valid, front_index, front_color, front_valid, queue_count,
                  is_member, status, output ready);
endinterface

`default_nettype wire

### src/fifo_with_membership_bitmap_unit.sv
// Top level of the FIFO with membership bitmap: entry ring, presence bitmap and control.
// Depends on fwmb_pkg and on the channel interfaces in fwmb_if.sv.
`default_nettype none

// A bounded queue of (vertex index, color) entries with one presence bit per vertex.
// Each command transfer yields exactly one result transfer. A command runs as a read
// followed by a write-back: in the transfer cycle the ring slot at the read pointer and
// the bitmap bit of the vertex index are read from their memories; in the execute state,
// once the output register is free, the ring and bitmap are written back and the result
// is loaded into the output register. Because of this read-then-write sequence on the two
// single-port-write memories, a new command is not taken until the last one is written back.
// The output register lets a new command transfer while a result still waits; the
// write-back stage then holds until that result leaves. After reset the bitmap memory
// is cleared one bit per cycle, while req.ready stays low.
module fifo_with_membership_bitmap_unit (
  input  wire logic   clk,
  input  wire logic   rst,
  fwmb_req_if.sink    req,
  fwmb_rsp_if.source  rsp
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Memories.
  fwmb_pkg::entry_t ring_mem   [fwmb_pkg::QUEUE_DEPTH];
  logic             bitmap_mem [fwmb_pkg::NUM_VERTICES];

  // Queue pointers and count.
  logic [fwmb_pkg::PTR_W-1:0]   read_ptr;
  logic [fwmb_pkg::PTR_W-1:0]   write_ptr;
  logic [fwmb_pkg::CNT_W-1:0]   entry_count;
  logic [fwmb_pkg::VADDR_W-1:0] clr_addr;

  // Latched command.
  logic [fwmb_pkg::CMD_W-1:0]   cmd_q;
  logic [fwmb_pkg::VIDX_W-1:0]  vidx_q;
  logic [fwmb_pkg::COLOR_W-1:0] color_q;

  // Registered read data.
  fwmb_pkg::entry_t ring_rd;
  logic             bit_rd;

  // Output register.
  logic                            rsp_valid;
  logic [fwmb_pkg::VIDX_W-1:0]     rsp_index;
  logic [fwmb_pkg::COLOR_W-1:0]    rsp_color;
  logic                            rsp_front_valid;
  logic [fwmb_pkg::QCOUNT_W-1:0]   rsp_count;
  logic                            rsp_member;
  logic [fwmb_pkg::STATUS_W-1:0]   rsp_status;

  logic req_fire;
  logic exec_go;
  logic in_range;
  logic pop_in_range;
  logic is_full;
  logic is_empty;
  logic push_ok;
  logic pop_ok;

  logic                            bm_we;
  logic [fwmb_pkg::VADDR_W-1:0]    bm_waddr;
  logic                            bm_wdata;

  logic                            res_front_valid;
  fwmb_pkg::entry_t                res_front;
  logic                            res_member;
  logic [fwmb_pkg::STATUS_W-1:0]   res_status;
  logic [fwmb_pkg::CNT_W-1:0]      count_after;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign exec_go   = (state == S_EXEC) && (!rsp_valid || rsp.ready);

  // Command decode against the state before the command.
  assign in_range     = 32'(vidx_q) < fwmb_pkg::NUM_VERTICES;
  assign pop_in_range = 32'(ring_rd.vidx) < fwmb_pkg::NUM_VERTICES;
  assign is_full      = entry_count == fwmb_pkg::CNT_W'(fwmb_pkg::QUEUE_DEPTH);
  assign is_empty     = entry_count == '0;
  assign push_ok      = (cmd_q == fwmb_pkg::CMD_PUSH) && in_range && !is_full;
  assign pop_ok       = (cmd_q == fwmb_pkg::CMD_POP) && !is_empty;

  // Result of the command in the write-back cycle.
  always_comb begin
    res_status      = fwmb_pkg::ST_OK;
    res_front_valid = 1'b0;
    res_front       = '0;
    res_member      = in_range && bit_rd;
    count_after     = entry_count;
    unique case (cmd_q)
      fwmb_pkg::CMD_PUSH: begin
        if (!in_range) begin
          res_status = fwmb_pkg::ST_OUT_RANGE;
        end else if (is_full) begin
          res_status = fwmb_pkg::ST_FULL;
        end else begin
          res_member  = 1'b1;
          count_after = entry_count + 1'b1;
        end
        if (!is_empty) begin
          res_front_valid = 1'b1;
          res_front       = ring_rd;
        end else if (push_ok) begin
          res_front_valid = 1'b1;
          res_front.vidx  = vidx_q;
          res_front.color = color_q;
        end
      end
      fwmb_pkg::CMD_POP: begin
        if (is_empty) begin
          res_status = fwmb_pkg::ST_EMPTY;
        end else begin
          res_front_valid = 1'b1;
          res_front       = ring_rd;
          count_after     = entry_count - 1'b1;
          if (pop_in_range && (ring_rd.vidx == vidx_q)) begin
            res_member = 1'b0;
          end
        end
      end
      default: begin
        if (!in_range) begin
          res_status = fwmb_pkg::ST_OUT_RANGE;
        end
        if (!is_empty) begin
          res_front_valid = 1'b1;
          res_front       = ring_rd;
        end
      end
    endcase
  end

  // Bitmap write port: clearing pass, set on push, clear on pop.
  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = clr_addr;
    bm_wdata = 1'b0;
    if (state == S_CLEAR) begin
      bm_we = 1'b1;
    end else if (exec_go && push_ok) begin
      bm_we    = 1'b1;
      bm_waddr = fwmb_pkg::VADDR_W'(vidx_q);
      bm_wdata = 1'b1;
    end else if (exec_go && pop_ok && pop_in_range) begin
      bm_we    = 1'b1;
      bm_waddr = fwmb_pkg::VADDR_W'(ring_rd.vidx);
    end
  end

  // Bitmap memory.
  always_ff @(posedge clk) begin
    if (bm_we) begin
      bitmap_mem[bm_waddr] <= bm_wdata;
    end
    if (req_fire) begin
      bit_rd <= bitmap_mem[fwmb_pkg::VADDR_W'(req.vertex_index)];
    end
  end

  // Entry ring memory.
  always_ff @(posedge clk) begin
    if (exec_go && push_ok) begin
      ring_mem[write_ptr] <= '{vidx: vidx_q, color: color_q};
    end
    if (req_fire) begin
      ring_rd <= ring_mem[read_ptr];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == fwmb_pkg::VADDR_W'(fwmb_pkg::NUM_VERTICES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_fire) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      read_ptr    <= '0;
      write_ptr   <= '0;
      entry_count <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (exec_go) begin
        entry_count <= count_after;
        if (push_ok) begin
          write_ptr <= (write_ptr == fwmb_pkg::PTR_W'(fwmb_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : write_ptr + 1'b1;
        end
        if (pop_ok) begin
          read_ptr <= (read_ptr == fwmb_pkg::PTR_W'(fwmb_pkg::QUEUE_DEPTH - 1)) ?
                      '0 : read_ptr + 1'b1;
        end
      end
      if (exec_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Command latch and output payload.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      cmd_q   <= req.cmd;
      vidx_q  <= req.vertex_index;
      color_q <= req.vertex_color;
    end
    if (exec_go) begin
      rsp_index       <= res_front.vidx;
      rsp_color       <= res_front.color;
      rsp_front_valid <= res_front_valid;
      rsp_count       <= fwmb_pkg::QCOUNT_W'(count_after);
      rsp_member      <= res_member;
      rsp_status      <= res_status;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.front_index = rsp_index;
  assign rsp.front_color = rsp_color;
  assign rsp.front_valid = rsp_front_valid;
  assign rsp.queue_count = rsp_count;
  assign rsp.is_member   = rsp_member;
  assign rsp.status      = rsp_status;

endmodule

`default_nettype wire
